// ----- hw/rtl/vae_pkg.sv -----
`timescale 1ns / 1ps

package vae_pkg;

  // Element and accumulator geometry.
  localparam int ELEM_WIDTH = 16;
  localparam int SUM_WIDTH  = ELEM_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * SUM_WIDTH;
  localparam int ACC_WIDTH  = 48;

  // Square root geometry: one result bit per iteration.
  localparam int ROOT_WIDTH = ACC_WIDTH / 2;
  localparam int REM_WIDTH  = ROOT_WIDTH + 2;
  localparam int CNT_WIDTH  = $clog2(ROOT_WIDTH + 1);

  // Stream packing.
  localparam int OP_WIDTH       = 3;
  localparam int IN_DATA_WIDTH  = ((2 * ELEM_WIDTH + 2 + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((ACC_WIDTH + 7) / 8) * 8;

  // Request types.
  localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_WIDTH-1:0] OP_DOT  = 3'd2;
  localparam logic [OP_WIDTH-1:0] OP_NORM = 3'd3;
  localparam logic [OP_WIDTH-1:0] OP_DIST = 3'd4;

  // Result kinds.
  localparam logic KIND_ELEM   = 1'b0;
  localparam logic KIND_SCALAR = 1'b1;

  // Sequencer controls for the shared arithmetic unit.
  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    logic                load_prod;
    logic                acc_en;
    logic                acc_clr;
  } alu_ctrl_t;

  // Square root unit status.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ----- hw/rtl/vae_alu.sv -----
`timescale 1ns / 1ps

module vae_alu
  import vae_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  alu_ctrl_t                   ctrl,
  input  logic signed [ELEM_WIDTH-1:0] elem_a,
  input  logic signed [ELEM_WIDTH-1:0] elem_b,
  output logic signed [SUM_WIDTH-1:0]  elem_res,
  output logic signed [ACC_WIDTH-1:0]  acc_next
);

  logic signed [SUM_WIDTH-1:0]  ext_a;
  logic signed [SUM_WIDTH-1:0]  ext_b;
  logic signed [SUM_WIDTH-1:0]  mul_x;
  logic signed [SUM_WIDTH-1:0]  mul_y;
  logic signed [PROD_WIDTH-1:0] mul_out;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [ACC_WIDTH-1:0]  acc;
  logic signed [ACC_WIDTH:0]    acc_wide;
  logic signed [ACC_WIDTH:0]    prod_wide;
  logic signed [ACC_WIDTH:0]    sum_wide;

  // Shared element adder: sum for add, difference for sub and distance.
  assign ext_a    = {elem_a[ELEM_WIDTH-1], elem_a};
  assign ext_b    = {elem_b[ELEM_WIDTH-1], elem_b};
  assign elem_res = (ctrl.op == OP_ADD) ? ext_a + ext_b : ext_a - ext_b;

  // Multiplier operands: a*b, a*a, or the difference squared.
  always_comb begin
    case (ctrl.op)
      OP_DOT: begin
        mul_x = ext_a;
        mul_y = ext_b;
      end
      OP_NORM: begin
        mul_x = ext_a;
        mul_y = ext_a;
      end
      default: begin
        mul_x = elem_res;
        mul_y = elem_res;
      end
    endcase
  end

  assign mul_out = mul_x * mul_y;

  // Product register in front of the accumulator adder.
  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod <= mul_out;
    end
  end

  // Saturating accumulate.
  assign acc_wide  = {acc[ACC_WIDTH-1], acc};
  assign prod_wide = {{(ACC_WIDTH + 1 - PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};
  assign sum_wide  = acc_wide + prod_wide;

  always_comb begin
    if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
      acc_next = sum_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                     : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_next = sum_wide[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- hw/rtl/vae_sqrt.sv -----
`timescale 1ns / 1ps

module vae_sqrt
  import vae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ACC_WIDTH-1:0]  operand,
  output sqrt_stat_t            stat,
  output logic [ROOT_WIDTH-1:0] root
);

  logic [ACC_WIDTH-1:0] src;
  logic [REM_WIDTH-1:0] rem;
  logic [REM_WIDTH-1:0] rem_sh;
  logic [REM_WIDTH-1:0] trial;
  logic                 fits;
  logic [CNT_WIDTH-1:0] cnt;
  logic                 busy;
  logic                 done;

  // One compare and subtract per iteration, two operand bits consumed.
  assign rem_sh = {rem[REM_WIDTH-3:0], src[ACC_WIDTH-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      src  <= operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src  <= {src[ACC_WIDTH-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_WIDTH-2:0], fits};
    end
  end

  // Iteration counter and status.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(ROOT_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- hw/rtl/vector_arith_engine.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Signals                               Contents
// s_*      in   tvalid tready tdata tuser tlast       element pair request
// m_*      out  tvalid tready tdata tuser tlast       element or scalar result
//
// One request at a time. Add and sub pass through the execute and output states;
// every pair before the last passes through execute and accumulate, and a last
// dot pair adds the output state. A last norm or distance pair waits in the root
// state for the bit-serial square root with its single compare-subtract unit.
// Reset (rst, synchronous) clears the sequencer, accumulator and output valid.
// A stalled m_tready holds the result; a new request is still taken while
// that result waits, and is held back only when it has its own result ready.

module vector_arith_engine
  import vae_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // elem_a [15:0], elem_b [31:16], a_present [32], b_present [33], zeros
  input  logic [IN_DATA_WIDTH-1:0]  s_tdata,
  // req_type [2:0]
  input  logic [OP_WIDTH-1:0]       s_tuser,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // result_value [47:0]
  output logic [OUT_DATA_WIDTH-1:0] m_tdata,
  // result_kind [0]
  output logic [0:0]                m_tuser,
  output logic                      m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [OP_WIDTH-1:0]          op;
  logic signed [ELEM_WIDTH-1:0] elem_a;
  logic signed [ELEM_WIDTH-1:0] elem_b;
  logic                         last;
  logic [ACC_WIDTH-1:0]         res_value;
  logic                         res_kind;
  logic                         res_last;
  logic                         res_load;
  logic [ACC_WIDTH-1:0]         res_value_next;
  logic                         res_kind_next;
  logic                         res_last_next;
  alu_ctrl_t                    ctrl;
  logic signed [SUM_WIDTH-1:0]  elem_res;
  logic signed [ACC_WIDTH-1:0]  acc_next;
  logic                         sqrt_start;
  logic [ACC_WIDTH-1:0]         sqrt_operand;
  sqrt_stat_t                   stat;
  logic [ROOT_WIDTH-1:0]        root;
  logic                         accept;
  logic                         out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Request capture; a missing element reads as zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= s_tuser;
      elem_a <= s_tdata[2*ELEM_WIDTH] ? s_tdata[ELEM_WIDTH-1:0] : '0;
      elem_b <= s_tdata[2*ELEM_WIDTH+1] ? s_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH] : '0;
      last   <= s_tlast;
    end
  end

  // Sequencer.
  always_comb begin
    state_next     = state;
    ctrl.op        = op;
    ctrl.load_prod = 1'b0;
    ctrl.acc_en    = 1'b0;
    ctrl.acc_clr   = 1'b0;
    sqrt_start     = 1'b0;
    sqrt_operand   = acc_next[ACC_WIDTH-1] ? '0 : acc_next;
    res_load       = 1'b0;
    res_value_next = {{(ACC_WIDTH-SUM_WIDTH){elem_res[SUM_WIDTH-1]}}, elem_res};
    res_kind_next  = KIND_ELEM;
    res_last_next  = last;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser <= OP_DIST) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op == OP_ADD || op == OP_SUB) begin
          res_load     = 1'b1;
          ctrl.acc_clr = last;
          state_next   = ST_OUT;
        end else begin
          ctrl.load_prod = 1'b1;
          state_next     = ST_ACC;
        end
      end
      ST_ACC: begin
        if (!last) begin
          ctrl.acc_en = 1'b1;
          state_next  = ST_IDLE;
        end else if (op == OP_DOT) begin
          res_load       = 1'b1;
          res_value_next = acc_next;
          res_kind_next  = KIND_SCALAR;
          res_last_next  = 1'b1;
          ctrl.acc_clr   = 1'b1;
          state_next     = ST_OUT;
        end else begin
          sqrt_start   = 1'b1;
          ctrl.acc_clr = 1'b1;
          state_next   = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (stat.done) begin
          res_load       = 1'b1;
          res_value_next = {{(ACC_WIDTH-ROOT_WIDTH){1'b0}}, root};
          res_kind_next  = KIND_SCALAR;
          res_last_next  = 1'b1;
          state_next     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pending result.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value <= res_value_next;
      res_kind  <= res_kind_next;
      res_last  <= res_last_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata    <= OUT_DATA_WIDTH'(res_value);
      m_tuser[0] <= res_kind;
      m_tlast    <= res_last;
    end
  end

  vae_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .elem_a   (elem_a),
    .elem_b   (elem_b),
    .elem_res (elem_res),
    .acc_next (acc_next)
  );

  vae_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand (sqrt_operand),
    .stat    (stat),
    .root    (root)
  );

  // The root unit runs only while the sequencer waits for it.
  a_sqrt_busy_in_root: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> state == ST_ROOT)
    else $error("square root unit busy outside the root state");

  a_sqrt_done_in_root: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == ST_ROOT)
    else $error("square root finished outside the root state");

  a_out_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result handoff did not present the result and return to idle");

  a_ignored_request: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser > OP_DIST) |=> state == ST_IDLE)
    else $error("unknown request type started work");

endmodule

// ----- dv/vector_arith_engine_tb.sv -----
`timescale 1ns / 1ps

module vector_arith_engine_tb;
  import vae_pkg::*;

  // Request types that the engine drops without a result or a state change.
  localparam logic [OP_WIDTH-1:0] OP_NONE_FIRST = 3'd5;
  localparam logic [OP_WIDTH-1:0] OP_NONE_MID   = 3'd6;
  localparam logic [OP_WIDTH-1:0] OP_NONE_LAST  = 3'd7;

  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = 16'sh8000;

  localparam longint RUN_MAX = (longint'(1) << (ACC_WIDTH - 1)) - 1;
  localparam longint RUN_MIN = -RUN_MAX - 1;

  localparam int RANDOM_PAIRS = 490;
  localparam int LONG_HOLD    = 400;

  // One element pair request, plus the idle cycles to leave before it and
  // whether the sender must first wait for every pending result.
  typedef struct {
    logic [OP_WIDTH-1:0]          op;
    logic signed [ELEM_WIDTH-1:0] a;
    logic signed [ELEM_WIDTH-1:0] b;
    bit                           a_on;
    bit                           b_on;
    bit                           last;
    int unsigned                  gap;
    bit                           drain;
  } elem_pair_t;

  typedef struct {
    logic [ACC_WIDTH-1:0] value;
    logic                 kind;
    logic                 fin;
  } engine_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_WIDTH-1:0]  s_tdata = '0;
  logic [OP_WIDTH-1:0]       s_tuser = '0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_tdata;
  logic [0:0]                m_tuser;
  logic                      m_tlast;

  elem_pair_t     pair_q[$];
  engine_result_t pending_results[$];
  longint         run_sum = 0;
  int             errors = 0;

  vector_arith_engine uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Idle gap for one request or one result: mostly none, sometimes a random one.
  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic logic [ELEM_WIDTH-1:0] pick_elem();
    case ($urandom_range(0, 11))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return ELEM_WIDTH'($urandom());
    endcase
  endfunction

  function automatic elem_pair_t mk_pair(logic [OP_WIDTH-1:0] op,
                                         logic [ELEM_WIDTH-1:0] a,
                                         logic [ELEM_WIDTH-1:0] b,
                                         bit a_on, bit b_on, bit last);
    elem_pair_t p;
    p.op = op;
    p.a = a;
    p.b = b;
    p.a_on = a_on;
    p.b_on = b_on;
    p.last = last;
    p.gap = draw_wait();
    p.drain = 1'b0;
    return p;
  endfunction

  // Saturating add into the running sum.
  function automatic void add_clamped(longint p);
    if (p > 0 && run_sum > RUN_MAX - p) begin
      run_sum = RUN_MAX;
    end else if (p < 0 && run_sum < RUN_MIN - p) begin
      run_sum = RUN_MIN;
    end else begin
      run_sum += p;
    end
  endfunction

  function automatic void add_square(longint d);
    longint mag;
    longint sq;
    mag = (d < 0) ? -d : d;
    sq = mag * mag;
    if (sq > RUN_MAX) sq = RUN_MAX;
    add_clamped(sq);
  endfunction

  // Bitwise integer square root, floor of sqrt(x).
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem = x;
    root = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Applies one accepted pair to the running sum and records the result it gives.
  function automatic void apply_pair(elem_pair_t p);
    longint a;
    longint b;
    engine_result_t r;
    if (p.op > OP_DIST) return;
    a = p.a_on ? longint'(p.a) : 0;
    b = p.b_on ? longint'(p.b) : 0;
    if (p.op == OP_ADD || p.op == OP_SUB) begin
      r.value = (p.op == OP_ADD) ? ACC_WIDTH'(a + b) : ACC_WIDTH'(a - b);
      r.kind = KIND_ELEM;
      r.fin = p.last;
      if (p.last) run_sum = 0;
      pending_results.push_back(r);
      return;
    end
    case (p.op)
      OP_DOT:  add_clamped(a * b);
      OP_NORM: add_square(a);
      default: add_square(a - b);
    endcase
    if (!p.last) return;
    if (p.op == OP_DOT) begin
      r.value = ACC_WIDTH'(run_sum);
    end else begin
      r.value = ACC_WIDTH'(floor_root((run_sum < 0) ? 0 : run_sum));
    end
    r.kind = KIND_SCALAR;
    r.fin = 1'b1;
    run_sum = 0;
    pending_results.push_back(r);
  endfunction

  // Run of identical pairs with no idling between them.
  task automatic queue_burst(logic [OP_WIDTH-1:0] op, logic [ELEM_WIDTH-1:0] a,
                             logic [ELEM_WIDTH-1:0] b, int count);
    elem_pair_t p;
    p = mk_pair(op, a, b, 1'b1, 1'b1, 1'b0);
    p.gap = 0;
    for (int i = 0; i < count; i++) begin
      p.drain = (i == 0);
      pair_q.push_back(p);
    end
  endtask

  // One well-formed vector operation with random contents, vector lengths and
  // occasional presence noise, mixed request types and ignored requests.
  task automatic queue_vector_op(logic [OP_WIDTH-1:0] op, int len, bit drain);
    elem_pair_t p;
    elem_pair_t junk;
    int la;
    int lb;
    bit calm;
    calm = ($urandom_range(0, 3) == 0);
    la = len;
    lb = len;
    case ($urandom_range(0, 3))
      0: lb = $urandom_range(0, len);
      1: la = $urandom_range(0, len);
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      p = mk_pair(op, pick_elem(), pick_elem(), i < la, i < lb, i == len - 1);
      if (i != len - 1 && $urandom_range(0, 11) == 0) begin
        p.op = OP_WIDTH'($urandom_range(OP_ADD, OP_DIST));
      end
      if ($urandom_range(0, 9) == 0) p.a_on = 1'($urandom());
      if ($urandom_range(0, 9) == 0) p.b_on = 1'($urandom());
      if (calm) p.gap = 0;
      p.drain = drain && (i == 0);
      pair_q.push_back(p);
      if ($urandom_range(0, 39) == 0) begin
        junk = mk_pair(OP_WIDTH'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST)), pick_elem(),
                       pick_elem(), 1'($urandom()), 1'($urandom()), 1'($urandom()));
        pair_q.push_back(junk);
      end
    end
  endtask

  // Request driver: presents queued pairs, honoring idle gaps and drain points.
  always @(posedge clk) begin : request_driver
    elem_pair_t cur;
    int unsigned idle_left;
    bit gap_taken;
    if (rst) begin
      s_tvalid <= 1'b0;
      idle_left = 0;
      gap_taken = 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) apply_pair(cur);
      if (idle_left != 0) begin
        idle_left--;
        s_tvalid <= 1'b0;
      end else if (pair_q.size() == 0 || (pair_q[0].drain && pending_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else if (pair_q[0].gap != 0 && !gap_taken) begin
        idle_left = pair_q[0].gap - 1;
        gap_taken = 1'b1;
        s_tvalid <= 1'b0;
      end else begin
        cur = pair_q.pop_front();
        gap_taken = 1'b0;
        s_tdata <= IN_DATA_WIDTH'({cur.b_on, cur.a_on, cur.b, cur.a});
        s_tuser <= cur.op;
        s_tlast <= cur.last;
        s_tvalid <= 1'b1;
      end
    end
  end

  task automatic check_result();
    engine_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual value %h kind %b last %b",
               $time, m_tdata[ACC_WIDTH-1:0], m_tuser[0], m_tlast);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (m_tdata[ACC_WIDTH-1:0] !== want.value) begin
      $display("%0t: result_value expected %h actual %h", $time, want.value,
               m_tdata[ACC_WIDTH-1:0]);
      errors++;
    end
    if (m_tuser[0] !== want.kind) begin
      $display("%0t: result_kind expected %b actual %b", $time, want.kind, m_tuser[0]);
      errors++;
    end
    if (m_tlast !== want.fin) begin
      $display("%0t: result_last expected %b actual %b", $time, want.fin, m_tlast);
      errors++;
    end
  endtask

  // Result monitor: checks each result and stalls the output side at random,
  // once for a long stretch so that the engine backs up into its input.
  always @(posedge clk) begin : result_monitor
    int unsigned hold;
    int unsigned hold_left;
    int seen;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      seen = 0;
    end else begin
      hold = hold_left;
      if (m_tvalid && m_tready) begin
        check_result();
        seen++;
        if (seen == 30) begin
          hold = LONG_HOLD;
        end else begin
          hold = ((seen / 24) % 3 == 0) ? 0 : draw_wait();
        end
      end
      if (hold != 0) begin
        hold_left = hold - 1;
        m_tready <= 1'b0;
      end else begin
        hold_left = 0;
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;

    // Directed part: add and sub extremes and missing elements.
    pair_q.push_back(mk_pair(OP_ADD, ELEM_MAX, ELEM_MAX, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_ADD, ELEM_MIN, ELEM_MIN, 1'b1, 1'b1, 1'b1));
    pair_q.push_back(mk_pair(OP_SUB, 16'h5a5a, 16'h04d2, 1'b0, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_SUB, ELEM_MIN, ELEM_MAX, 1'b1, 1'b0, 1'b0));
    pair_q.push_back(mk_pair(OP_SUB, ELEM_MAX, ELEM_MIN, 1'b1, 1'b1, 1'b1));
    pair_q.push_back(mk_pair(OP_ADD, 16'h1234, 16'hfedc, 1'b0, 1'b0, 1'b1));
    // Dot with extreme products.
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MIN, ELEM_MIN, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MIN, ELEM_MAX, 1'b1, 1'b1, 1'b1));
    // Norm of the first vector, the second one being ignored.
    pair_q.push_back(mk_pair(OP_NORM, ELEM_MIN, 16'h7777, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_NORM, 16'h0180, ELEM_MAX, 1'b1, 1'b0, 1'b1));
    // Distance with a missing element in the first vector.
    pair_q.push_back(mk_pair(OP_DIST, ELEM_MAX, ELEM_MIN, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_DIST, 16'h0100, ELEM_MIN, 1'b0, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_DIST, 16'h0001, 16'h0002, 1'b1, 1'b1, 1'b1));
    // Mixed types leaving a negative sum: the root is taken of zero.
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MIN, ELEM_MAX, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_NORM, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1));
    // An element result marked last clears the sum of a running dot.
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MAX, ELEM_MAX, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_ADD, 16'h0003, 16'h0004, 1'b1, 1'b1, 1'b1));
    pair_q.push_back(mk_pair(OP_DOT, 16'h0200, 16'hff00, 1'b1, 1'b1, 1'b1));
    // Ignored request types, even marked last, leave the sum alone.
    pair_q.push_back(mk_pair(OP_DOT, 16'h0300, 16'h0300, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_NONE_FIRST, ELEM_MAX, ELEM_MAX, 1'b1, 1'b1, 1'b1));
    pair_q.push_back(mk_pair(OP_NONE_MID, 16'h00ff, ELEM_MIN, 1'b0, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_NONE_LAST, ELEM_MIN, 16'h00ff, 1'b1, 1'b0, 1'b1));
    pair_q.push_back(mk_pair(OP_DOT, 16'h0100, 16'h0100, 1'b1, 1'b1, 1'b1));
    // Single-element norm of zero.
    pair_q.push_back(mk_pair(OP_NORM, 16'h0000, ELEM_MIN, 1'b1, 1'b1, 1'b1));

    // Back-to-back distance run, then a negative product before the root.
    queue_burst(OP_DIST, ELEM_MAX, ELEM_MIN, 8);
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MIN, ELEM_MAX, 1'b1, 1'b1, 1'b0));
    pair_q.push_back(mk_pair(OP_DIST, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1));
    // Back-to-back run of negative products.
    queue_burst(OP_DOT, ELEM_MIN, ELEM_MAX, 8);
    pair_q.push_back(mk_pair(OP_DOT, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
    pair_q.push_back(mk_pair(OP_DOT, ELEM_MAX, ELEM_MAX, 1'b1, 1'b1, 1'b1));

    // Random vector operations, with a full drain now and then.
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      queue_vector_op(OP_WIDTH'($urandom_range(OP_ADD, OP_DIST)), len,
                      $urandom_range(0, 14) == 0);
      sent += len;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pair_q.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[vector_arith_engine] OK");
    end else begin
      $display("[vector_arith_engine] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("[vector_arith_engine] ERROR");
    $finish;
  end

endmodule
